/* hdl/relr_relocation_decoder_core_assert.svh */
// Assertion macros shared by the relocation decoder modules.
`ifndef RELR_RELOCATION_DECODER_CORE_ASSERT_SVH
`define RELR_RELOCATION_DECODER_CORE_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define RELR_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define RELR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/relr_pkg.sv */
// Types shared by the relocation decoder: channel words and queue entry.
`timescale 1ns / 1ps

package relr_pkg;

  localparam int unsigned ADDR_W = 64;

  // Input word: one relocation table entry.
  typedef struct packed {
    logic [ADDR_W-1:0] table_word;
    logic              end_of_table;
  } in_word_t;

  // Output word: one patch address.
  typedef struct packed {
    logic [ADDR_W-1:0] patch_address;
    logic              last_patch;
  } out_word_t;

  // Classified entry between front and back.
  typedef struct packed {
    logic              is_bitmap;
    logic              end_of_table;
    logic [ADDR_W-1:0] value;  // absolute address, or raw bitmap word
  } relr_entry_t;

endpackage

/* hdl/relr_front.sv */
// Front end: load base register, word classification and entry queue.
`timescale 1ns / 1ps

module relr_front #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  relr_pkg::in_word_t    in_word,
  input  logic                  cfg_write,
  input  logic [63:0]           cfg_data,
  output logic                  q_valid,
  output relr_pkg::relr_entry_t q_entry,
  input  logic                  q_pop
);
  import relr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ADDR_W-1:0] load_base;
  relr_entry_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  relr_entry_t       new_entry;
  logic              do_push;
  logic              do_pop;

  // Load base register
  always_ff @(posedge clk) begin
    if (rst) begin
      load_base <= '0;
    end else if (cfg_write) begin
      load_base <= cfg_data;
    end
  end

  // Classify: address words are rebased here, bitmaps pass as they are
  always_comb begin
    new_entry.is_bitmap    = in_word.table_word[0];
    new_entry.end_of_table = in_word.end_of_table;
    if (in_word.table_word[0]) begin
      new_entry.value = in_word.table_word;
    end else begin
      new_entry.value = load_base + in_word.table_word;
    end
  end

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= new_entry;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

`include "relr_relocation_decoder_core_assert.svh"
  `RELR_ASSERT_ALWAYS(a_count_range, clk, rst, count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `RELR_ASSERT_ALWAYS(a_empty_ptrs, clk, rst, (count != '0) || (rd_ptr == wr_ptr), "pointers differ on empty queue")

endmodule

/* hdl/relr_back.sv */
// Back end: running pointer, bitmap scanner and result register.
`timescale 1ns / 1ps

module relr_back #(
  parameter int unsigned WORD_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  relr_pkg::relr_entry_t q_entry,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output relr_pkg::out_word_t   out_word
);
  import relr_pkg::*;

  localparam int unsigned BITMAP_BITS = WORD_BYTES * 8 - 1;
  localparam logic [62:0] BITMAP_MASK = 63'((65'd1 << BITMAP_BITS) - 65'd1);
  localparam logic [ADDR_W-1:0] STEP  = ADDR_W'(WORD_BYTES);
  localparam logic [ADDR_W-1:0] CHUNK = ADDR_W'(8 * WORD_BYTES);
  localparam logic [ADDR_W-1:0] ADV   = ADDR_W'(BITMAP_BITS * WORD_BYTES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic              state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] cur, cur_next;
  logic [62:0]       mask, mask_next;
  logic              scan_end, scan_end_next;
  logic              out_valid, out_valid_next;
  out_word_t         out_reg, out_reg_next;

  logic              slot_free;
  logic [62:0]       bm;
  logic [7:0]        low8;
  logic [7:0]        low_one;
  logic [2:0]        low_idx;
  logic [62:0]       mask_clr;

  assign slot_free = !out_valid || pop;
  assign bm        = q_entry.value[63:1] & BITMAP_MASK;
  assign low8      = mask[7:0];
  assign low_one   = low8 & (~low8 + 8'd1);
  assign mask_clr  = mask & ~{55'd0, low_one};

  // Index of the lowest set bit in the current group of eight
  always_comb begin
    low_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (low8[i]) begin
        low_idx = 3'(i);
      end
    end
  end

  // Sequencer: one result per cycle unless stalled; skips empty groups
  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    cur_next       = cur;
    mask_next      = mask;
    scan_end_next  = scan_end;
    out_valid_next = out_valid && !pop;
    out_reg_next   = out_reg;
    q_pop          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (!q_entry.is_bitmap) begin
            out_reg_next.patch_address = q_entry.value;
            out_reg_next.last_patch    = 1'b1;
            out_valid_next             = 1'b1;
            ptr_next = q_entry.end_of_table ? '0 : q_entry.value + STEP;
          end else if (bm == '0) begin
            ptr_next = q_entry.end_of_table ? '0 : ptr + ADV;
          end else begin
            mask_next     = bm;
            cur_next      = ptr;
            scan_end_next = q_entry.end_of_table;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (low8 != '0) begin
          if (slot_free) begin
            out_reg_next.patch_address = cur + ADDR_W'(low_idx) * STEP;
            out_reg_next.last_patch    = (mask_clr == '0);
            out_valid_next             = 1'b1;
            mask_next                  = mask_clr;
            if (mask_clr == '0) begin
              ptr_next   = scan_end ? '0 : ptr + ADV;
              state_next = ST_IDLE;
            end
          end
        end else begin
          mask_next = mask >> 8;
          cur_next  = cur + CHUNK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      out_valid <= out_valid_next;
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    mask     <= mask_next;
    scan_end <= scan_end_next;
    out_reg  <= out_reg_next;
  end

  assign empty    = !out_valid;
  assign out_word = out_reg;

`include "relr_relocation_decoder_core_assert.svh"
  `RELR_ASSERT_ALWAYS(a_scan_mask, clk, rst, (state != ST_SCAN) || (mask != '0), "scan with empty bitmap")
  `RELR_ASSERT_NEXT(a_result_hold, clk, rst, out_valid && !pop, out_valid && $stable(out_reg), "stalled result changed")

endmodule

/* hdl/relr_relocation_decoder_core.sv */
// Packed relative-relocation decoder: front queue plus back-end sequencer.
//
// Input channel: push/full carries one table word and its end-of-table flag;
// a word is taken at a clock edge with push high and full low. Words are
// classified and queued (QUEUE_DEPTH entries), so input keeps flowing while
// the back end is busy with a bitmap.
// Result channel: empty/pop; the oldest patch address sits on out_word while
// empty is low and leaves at an edge with pop high.
// Config: cfg_write with cfg_data loads the load base; write only when idle.
// Path: an address word is held in the queue, then in the result register.
// Throughput: an address word goes straight to the result register. A bitmap is
// taken from the queue, then gives one patch address per set bit, skipping each
// empty group of eight bitmap bits before the last set bit. The back-end sequencer
// sets the rate: one patch address per cycle save on stalls, bitmap loads, skips.
// Reset (rst, synchronous): queue emptied, running pointer and load base
// cleared, no result waiting.
// Receiver stall: the result register holds; the sequencer waits and the
// queue fills until full rises.
`timescale 1ns / 1ps

module relr_relocation_decoder_core #(
  parameter int unsigned WORD_BYTES  = 8,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  relr_pkg::in_word_t  in_word,
  output logic                empty,
  input  logic                pop,
  output relr_pkg::out_word_t out_word,
  input  logic                cfg_write,
  input  logic [63:0]         cfg_data
);
  import relr_pkg::*;

  logic        q_valid;
  logic        q_pop;
  relr_entry_t q_entry;

  relr_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  relr_back #(
    .WORD_BYTES (WORD_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule
